@@ hdl/ibmw_pkg.sv @@
// ----------------------------------------------------------------------------
// ibmw_pkg
// Shared types, constants and helper functions of the indirect block map
// walker.
// ----------------------------------------------------------------------------
package ibmw_pkg;

	localparam int DIRECT_SLOTS = 12;
	localparam int ROOT_SLOTS   = DIRECT_SLOTS + 3;
	localparam int SLOT_W       = $clog2(ROOT_SLOTS);
	localparam int P_MIN        = 8;
	localparam int P_MAX        = 14;
	localparam int P_RESET      = 10;
	localparam int WORD_W       = P_MAX;
	localparam int THR_W        = 3 * P_MAX + 2;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [THR_W-1:0]  thr_t;
	typedef logic [WORD_W-1:0] wofs_t;

	typedef enum logic [1:0] {
		K_LOAD   = 2'd0,
		K_APPEND = 2'd1,
		K_LOOKUP = 2'd2,
		K_WORD   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		RK_READ   = 2'd0,
		RK_ANSWER = 2'd1,
		RK_APPEND = 2'd2
	} rkind_t;

	typedef enum logic [2:0] {
		LK_DIRECT,
		LK_SINGLE,
		LK_DOUBLE,
		LK_TRIPLE,
		LK_OUT
	} lk_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} st_t;

	// Effective geometry: clamped log2 of pointers per block and the starts of
	// the double, triple and beyond-triple ranges.
	typedef struct packed {
		logic [3:0] p;
		thr_t       t2;
		thr_t       t3;
		thr_t       t4;
	} cfg_t;

	// Decoded lookup: range class, root table slot, remainder, first word offset.
	typedef struct packed {
		lk_t         cls;
		slot_t       addr;
		logic [31:0] rem;
		wofs_t       wofs;
	} lkp_t;

	typedef struct packed {
		rkind_t      result_kind;
		logic [31:0] read_block;
		wofs_t       read_word;
		logic        found;
		logic [31:0] physical_block;
		logic        append_ok;
	} res_t;

	function automatic logic [3:0] clamp_p(input logic [3:0] raw);
		logic [3:0] p;
		p = raw;
		if (p < 4'(P_MIN)) p = 4'(P_MIN);
		if (p > 4'(P_MAX)) p = 4'(P_MAX);
		return p;
	endfunction

	function automatic cfg_t geometry(input logic [3:0] p);
		cfg_t       c;
		logic [5:0] sh3;
		sh3  = 6'({p, 1'b0}) + 6'(p);
		c.p  = p;
		c.t2 = thr_t'(DIRECT_SLOTS) + (thr_t'(1) << p);
		c.t3 = c.t2 + (thr_t'(1) << {p, 1'b0});
		c.t4 = c.t3 + (thr_t'(1) << sh3);
		return c;
	endfunction

	// One digit of the remainder: (rem >> sh) masked to p bits.
	function automatic wofs_t word_ofs(input logic [31:0] rem, input logic [4:0] sh,
		input logic [3:0] p);
		logic [WORD_W:0] one;
		wofs_t           mask;
		one  = (WORD_W+1)'(1) << p;
		mask = WORD_W'(one - (WORD_W+1)'(1));
		return WORD_W'(rem >> sh) & mask;
	endfunction

endpackage

@@ hdl/indirect_block_map_walker_top.sv @@
// ----------------------------------------------------------------------------
// indirect_block_map_walker_top
// Maps a file's logical block index to a physical block through a root table
// of direct and single, double and triple indirect pointers.
// ----------------------------------------------------------------------------
// Appends, memory words returned during a walk and out-of-range lookups keep
// busy low, and the result beat appears on the cycle after the start beat;
// loads give no result beat. A lookup that needs a root table entry holds
// busy high while the root table RAM is read, and its result beat follows
// that read. Results are shown for exactly one cycle with done high
// and cannot be stalled; a new start may be given while done is high.
// Indirect lookups answer with a read request, and the caller returns each
// requested word as a memory-word item to continue the walk.
module indirect_block_map_walker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [3:0]  slot,
	input  logic [31:0] block_number,
	input  logic [31:0] logical_index,
	output logic        done,
	output logic [1:0]  result_kind,
	output logic [31:0] read_block,
	output logic [13:0] read_word,
	output logic        found,
	output logic [31:0] physical_block,
	output logic        append_ok,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);

	ibmw_pkg::cfg_t  cfg;
	ibmw_pkg::lkp_t  lkp;
	ibmw_pkg::st_t   state_q;
	ibmw_pkg::st_t   state_d;
	ibmw_pkg::res_t  res_q;
	ibmw_pkg::res_t  res_d;
	ibmw_pkg::lk_t   cls_s1;
	ibmw_pkg::wofs_t wofs_s1;
	logic            nzsel_s1;
	logic            done_q;
	logic            fire_d;
	logic [ibmw_pkg::ROOT_SLOTS-1:0] nz_q;
	logic [1:0]      levels_q;
	logic [31:0]     rem_q;
	logic            accept;
	logic            ram_we;
	ibmw_pkg::slot_t ram_waddr;
	logic [31:0]     ram_rdata;
	logic [31:0]     root_val;
	logic            free_hit;
	ibmw_pkg::slot_t free_idx;
	logic            slot_ok;

	ibmw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ibmw_decode u_decode (
		.logical_index (logical_index),
		.cfg           (cfg),
		.lkp           (lkp)
	);

	ibmw_ram #(
		.WIDTH (32),
		.DEPTH (ibmw_pkg::ROOT_SLOTS)
	) u_root (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (block_number),
		.raddr (lkp.addr),
		.rdata (ram_rdata)
	);

	assign busy    = (state_q == ibmw_pkg::ST_READ);
	assign accept  = start && !busy;
	assign slot_ok = {1'b0, slot} < 5'(ibmw_pkg::ROOT_SLOTS);

	// An entry never written, or written with zero, reads as zero.
	assign root_val = nzsel_s1 ? ram_rdata : 32'd0;

	// First empty direct slot.
	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		for (int i = ibmw_pkg::DIRECT_SLOTS - 1; i >= 0; i--) begin
			if (!nz_q[i]) begin
				free_hit = 1'b1;
				free_idx = ibmw_pkg::slot_t'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ibmw_pkg::ST_IDLE: begin
				if (accept && ibmw_pkg::kind_t'(kind) == ibmw_pkg::K_LOOKUP &&
						lkp.cls != ibmw_pkg::LK_OUT) begin
					state_d = ibmw_pkg::ST_READ;
				end
			end
			ibmw_pkg::ST_READ: state_d = ibmw_pkg::ST_IDLE;
			default: state_d = ibmw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		fire_d    = 1'b0;
		res_d     = '0;
		ram_we    = 1'b0;
		ram_waddr = ibmw_pkg::slot_t'(slot);
		case (state_q)
			ibmw_pkg::ST_READ: begin
				fire_d = 1'b1;
				if (cls_s1 == ibmw_pkg::LK_DIRECT) begin
					res_d.result_kind    = ibmw_pkg::RK_ANSWER;
					res_d.found          = nzsel_s1;
					res_d.physical_block = root_val;
				end else begin
					res_d.result_kind = ibmw_pkg::RK_READ;
					res_d.read_block  = root_val;
					res_d.read_word   = wofs_s1;
				end
			end
			ibmw_pkg::ST_IDLE: begin
				if (accept) begin
					case (ibmw_pkg::kind_t'(kind))
						ibmw_pkg::K_LOAD: ram_we = slot_ok;
						ibmw_pkg::K_APPEND: begin
							fire_d            = 1'b1;
							res_d.result_kind = ibmw_pkg::RK_APPEND;
							res_d.append_ok   = free_hit;
							ram_we            = free_hit;
							ram_waddr         = free_idx;
						end
						ibmw_pkg::K_LOOKUP: begin
							if (lkp.cls == ibmw_pkg::LK_OUT) begin
								fire_d            = 1'b1;
								res_d.result_kind = ibmw_pkg::RK_ANSWER;
							end
						end
						ibmw_pkg::K_WORD: begin
							case (levels_q)
								2'd1: begin
									fire_d               = 1'b1;
									res_d.result_kind    = ibmw_pkg::RK_ANSWER;
									res_d.found          = block_number != 32'd0;
									res_d.physical_block = block_number;
								end
								2'd2: begin
									fire_d            = 1'b1;
									res_d.result_kind = ibmw_pkg::RK_READ;
									res_d.read_block  = block_number;
									res_d.read_word   = ibmw_pkg::word_ofs(rem_q, 5'd0, cfg.p);
								end
								2'd3: begin
									fire_d            = 1'b1;
									res_d.result_kind = ibmw_pkg::RK_READ;
									res_d.read_block  = block_number;
									res_d.read_word   = ibmw_pkg::word_ofs(rem_q, 5'(cfg.p),
										cfg.p);
								end
								default: fire_d = 1'b0;
							endcase
						end
						default: fire_d = 1'b0;
					endcase
				end
			end
			default: fire_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ibmw_pkg::ST_IDLE;
			done_q   <= 1'b0;
			nz_q     <= '0;
			levels_q <= 2'd0;
			rem_q    <= 32'd0;
		end else begin
			state_q <= state_d;
			done_q  <= fire_d;
			if (ram_we) nz_q[ram_waddr] <= block_number != 32'd0;
			if (accept) begin
				if (ibmw_pkg::kind_t'(kind) == ibmw_pkg::K_LOOKUP) begin
					rem_q <= lkp.rem;
					case (lkp.cls)
						ibmw_pkg::LK_SINGLE: levels_q <= 2'd1;
						ibmw_pkg::LK_DOUBLE: levels_q <= 2'd2;
						ibmw_pkg::LK_TRIPLE: levels_q <= 2'd3;
						default: levels_q <= 2'd0;
					endcase
				end else if (ibmw_pkg::kind_t'(kind) == ibmw_pkg::K_WORD &&
						levels_q != 2'd0) begin
					levels_q <= levels_q - 2'd1;
					if (levels_q == 2'd1) rem_q <= 32'd0;
				end
			end
		end
	end

	// Lookup context held across the root table read.
	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (accept) begin
			cls_s1   <= lkp.cls;
			wofs_s1  <= lkp.wofs;
			nzsel_s1 <= nz_q[lkp.addr];
		end
	end

	assign done           = done_q;
	assign result_kind    = res_q.result_kind;
	assign read_block     = res_q.read_block;
	assign read_word      = res_q.read_word;
	assign found          = res_q.found;
	assign physical_block = res_q.physical_block;
	assign append_ok      = res_q.append_ok;

endmodule

@@ hdl/ibmw_ram.sv @@
// ----------------------------------------------------------------------------
// ibmw_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ibmw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/ibmw_cfg.sv @@
// ----------------------------------------------------------------------------
// ibmw_cfg
// Geometry register: holds the clamped pointers-per-block exponent and the
// range boundaries derived from it.
// ----------------------------------------------------------------------------
module ibmw_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [3:0]          cfg_data,
	output ibmw_pkg::cfg_t      cfg
);

	ibmw_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Boundaries are worked out once per write so lookups only compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ibmw_pkg::geometry(4'(ibmw_pkg::P_RESET));
		end else if (cfg_valid) begin
			cfg_q <= ibmw_pkg::geometry(ibmw_pkg::clamp_p(cfg_data));
		end
	end

endmodule

@@ hdl/ibmw_decode.sv @@
// ----------------------------------------------------------------------------
// ibmw_decode
// Range decoder for a lookup: picks direct, single, double, triple or out of
// range, the root slot to read and the first word offset of the walk.
// ----------------------------------------------------------------------------
module ibmw_decode (
	input  logic [31:0]    logical_index,
	input  ibmw_pkg::cfg_t cfg,
	output ibmw_pkg::lkp_t lkp
);

	ibmw_pkg::thr_t kx;
	logic [31:0]    d1;
	logic [31:0]    d2;
	logic [31:0]    d3;

	assign kx = ibmw_pkg::thr_t'(logical_index);
	assign d1 = logical_index - 32'(ibmw_pkg::DIRECT_SLOTS);
	assign d2 = logical_index - cfg.t2[31:0];
	assign d3 = logical_index - cfg.t3[31:0];

	always_comb begin
		lkp      = '0;
		lkp.cls  = ibmw_pkg::LK_OUT;
		if (kx < ibmw_pkg::thr_t'(ibmw_pkg::DIRECT_SLOTS)) begin
			lkp.cls  = ibmw_pkg::LK_DIRECT;
			lkp.addr = logical_index[ibmw_pkg::SLOT_W-1:0];
		end else if (kx < cfg.t2) begin
			lkp.cls  = ibmw_pkg::LK_SINGLE;
			lkp.addr = ibmw_pkg::slot_t'(ibmw_pkg::DIRECT_SLOTS);
			lkp.rem  = d1;
			lkp.wofs = ibmw_pkg::word_ofs(d1, 5'd0, cfg.p);
		end else if (kx < cfg.t3) begin
			lkp.cls  = ibmw_pkg::LK_DOUBLE;
			lkp.addr = ibmw_pkg::slot_t'(ibmw_pkg::DIRECT_SLOTS + 1);
			lkp.rem  = d2;
			lkp.wofs = ibmw_pkg::word_ofs(d2, 5'(cfg.p), cfg.p);
		end else if (kx < cfg.t4) begin
			lkp.cls  = ibmw_pkg::LK_TRIPLE;
			lkp.addr = ibmw_pkg::slot_t'(ibmw_pkg::DIRECT_SLOTS + 2);
			lkp.rem  = d3;
			lkp.wofs = ibmw_pkg::word_ofs(d3, 5'({cfg.p, 1'b0}), cfg.p);
		end
	end

endmodule
